// File: hw/rtl/power_rescale_run_length_encoder_macros.svh
// Assertion macros used by the run encoder of the power rescale run-length encoder RTL.
`ifndef POWER_RESCALE_RUN_LENGTH_ENCODER_MACROS_SVH
`define POWER_RESCALE_RUN_LENGTH_ENCODER_MACROS_SVH
`ifndef ASSERT_OFF
`define PRRE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
`define PRRE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PRRE_ASSERT_IMP(label, ante, cons)
`define PRRE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/prre_pkg.sv
// Shared types, constants and elaboration-time tables of the power rescale encoder.
package prre_pkg;

   localparam logic [10:0] SCORE_MAX       = 11'd1000;
   localparam logic [9:0]  VALUE_FULL      = 10'd1000;
   localparam logic [23:0] EXPONENT_RESET  = 24'd65536;
   localparam logic        CSR_IDX_EXPONENT = 1'b0;

   // Input transfer payload.
   typedef struct packed {
      logic [10:0] score;
      logic        end_of_region;
   } req_type;

   // Result transfer payload.
   typedef struct packed {
      logic [9:0]  run_value;
      logic [31:0] run_length;
      logic        bad_score;
      logic        region_done;
   } rsp_type;

   // Classified item held in the queue between front and back.
   typedef struct packed {
      logic [9:0] score;
      logic       end_of_region;
      logic       bad;
   } item_type;

   // Request to and answer from the rescale unit.
   typedef struct packed {
      logic        start;
      logic [9:0]  score;
      logic [23:0] exponent;
   } rs_req_type;

   typedef struct packed {
      logic       done;
      logic [9:0] value;
   } rs_rsp_type;

   // Base-2 logarithm in Q.32 by repeated squaring; used for constants only.
   function automatic logic [35:0] log2_q32(input logic [9:0] x);
      logic [63:0] m;
      logic [31:0] frac;
      int          e;
      e = 0;
      for (int i = 0; i < 10; i++) begin
         if (x[i]) e = i;
      end
      m = 64'(x) << (31 - e);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = {frac[30:0], 1'b0};
         if (m[32]) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return {4'(e), frac};
   endfunction

   // Integer square root, bounded loops for elaboration.
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x = x_in;
      res = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bit_v != '0) begin
            if (x >= res + bit_v) begin
               x = x - res - bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // Coefficients 2^(-2^-i) in Q.32 for i = 1..32, entry i-1 at bits [32*(i-1) +: 32].
   function automatic logic [1023:0] exp_coef_table();
      logic [1023:0] tab;
      logic [63:0]   c;
      tab = '0;
      c = isqrt64(64'h8000_0000_0000_0000);
      for (int i = 0; i < 32; i++) begin
         tab[i*32 +: 32] = c[31:0];
         c = isqrt64(c << 32);
      end
      return tab;
   endfunction

   localparam logic [35:0]   LOG2_1000 = log2_q32(10'd1000);
   localparam logic [1023:0] EXP_COEF  = exp_coef_table();

endpackage

// File: hw/rtl/prre_front.sv
// Front end: accepts input transfers, flags bad scores and queues the items.
module prre_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  prre_pkg::req_type  req_data,
   output logic               item_valid,
   input  logic               item_ready,
   output prre_pkg::item_type item
);
   import prre_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   item_type   classified;

   // Classify the incoming score.
   always_comb begin
      classified.bad           = (req_data.score > SCORE_MAX);
      classified.score         = req_data.score[9:0];
      classified.end_of_region = req_data.end_of_region;
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rd_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   // Queue pointers and fill count.
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= classified;
   end

endmodule

// File: hw/rtl/prre_rescale.sv
// Iterative rescale unit: log2 by squaring, exponent multiply, exp2 by coefficients.
module prre_rescale (
   input  logic                 clock,
   input  logic                 reset,
   input  prre_pkg::rs_req_type rs_req,
   output prre_pkg::rs_rsp_type rs_rsp
);
   import prre_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOG, S_DIFF, S_MUL_LO, S_MUL_HI, S_EXP, S_ROUND
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] m_ff, m_in;
   logic [31:0] frac_ff, frac_in;
   logic [3:0]  e_ff, e_in;
   logic [35:0] diff_ff, diff_in;
   logic [59:0] prod_ff, prod_in;
   logic [23:0] u_ff, u_in;
   logic [31:0] r_ff, r_in;
   logic        r_one_ff, r_one_in;
   logic        done_ff, done_in;
   logic [9:0]  value_ff, value_in;

   logic [3:0]  msb;
   logic [63:0] sq;
   logic [41:0] lo_mul, hi_mul;
   logic [31:0] coef;
   logic [63:0] em;
   logic [31:0] fbits;
   logic [11:0] n_int;
   logic [32:0] r_full, r_shift;
   logic [42:0] scaled;
   logic [35:0] lb;

   // Top bit of the score.
   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (rs_req.score[i]) msb = 4'(i);
      end
   end

   // Datapath shared by the iterations.
   assign sq      = 64'(m_ff) * 64'(m_ff);
   assign lo_mul  = 42'(diff_ff[17:0]) * 42'(u_ff);
   assign hi_mul  = 42'(diff_ff[35:18]) * 42'(u_ff);
   assign coef    = EXP_COEF[{step_ff, 5'b0} +: 32];
   assign em      = 64'(r_ff) * 64'(coef);
   assign fbits   = prod_ff[47:16];
   assign n_int   = prod_ff[59:48];
   assign r_full  = r_one_ff ? 33'h1_0000_0000 : {1'b0, r_ff};
   assign r_shift = r_full >> n_int[3:0];
   assign scaled  = 43'(r_shift) * 43'd1000 + 43'h0_8000_0000;
   assign lb      = {e_ff, frac_ff};

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      u_in     = u_ff;
      r_in     = r_ff;
      r_one_in = r_one_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (rs_req.start) begin
               u_in = rs_req.exponent;
               if (rs_req.score == 10'd0) begin
                  value_in = (rs_req.exponent == 24'd0) ? VALUE_FULL : 10'd0;
                  done_in  = 1'b1;
               end else if (rs_req.exponent == 24'd0) begin
                  value_in = VALUE_FULL;
                  done_in  = 1'b1;
               end else begin
                  e_in     = msb;
                  m_in     = 32'(rs_req.score) << (5'd31 - {1'b0, msb});
                  frac_in  = '0;
                  step_in  = 5'd0;
                  state_in = S_LOG;
               end
            end
         end
         S_LOG: begin
            // One fraction bit of the logarithm per square.
            m_in    = sq[63] ? sq[63:32] : sq[62:31];
            frac_in = {frac_ff[30:0], sq[63]};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = (lb > LOG2_1000) ? 36'd0 : LOG2_1000 - lb;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = 60'(lo_mul);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = prod_ff + {hi_mul, 18'b0};
            r_one_in = 1'b1;
            r_in     = '0;
            step_in  = 5'd0;
            state_in = S_EXP;
         end
         S_EXP: begin
            // Multiply in 2^(-2^-i) for each set fraction bit.
            if (fbits[5'd31 - step_ff]) begin
               if (r_one_ff) begin
                  r_in     = coef;
                  r_one_in = 1'b0;
               end else begin
                  r_in = em[63:32];
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) state_in = S_ROUND;
         end
         S_ROUND: begin
            if (n_int >= 12'd11) value_in = 10'd0;
            else if (scaled[42:32] > 11'(VALUE_FULL)) value_in = VALUE_FULL;
            else value_in = scaled[41:32];
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= 5'd0;
         r_one_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         r_one_ff <= r_one_in;
      end
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      e_ff     <= e_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      u_ff     <= u_in;
      r_ff     <= r_in;
      value_ff <= value_in;
   end

   assign rs_rsp.done  = done_ff;
   assign rs_rsp.value = value_ff;

endmodule

// File: hw/rtl/prre_run_encoder.sv
// Back end: run-length encoding of rescaled values and the result register.
`include "power_rescale_run_length_encoder_macros.svh"
module prre_run_encoder #(
   parameter int RUN_COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  prre_pkg::item_type   item,
   input  logic [23:0]          exponent,
   output prre_pkg::rs_req_type rs_req,
   input  prre_pkg::rs_rsp_type rs_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output prre_pkg::rsp_type    rsp_data
);
   import prre_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WAIT, S_SEND} state_type;

   state_type                 state_ff, state_in;
   logic                      eor_ff, eor_in;
   logic [9:0]                held_ff, held_in;
   logic [RUN_COUNT_BITS-1:0] count_ff, count_in;
   logic                      open_ff, open_in;
   rsp_type                   res0_ff, res0_in;
   rsp_type                   res1_ff, res1_in;
   logic [1:0]                nres_ff, nres_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      take;
   logic                      extend;
   logic                      out_free;
   logic [RUN_COUNT_BITS-1:0] count_next;
   logic [9:0]                held_next;
   rsp_type                   closed_run, final_run, bad_res;

   assign item_ready      = (state_ff == S_IDLE);
   assign take            = item_valid && item_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rs_req.start    = take && !item.bad;
   assign rs_req.score    = item.score;
   assign rs_req.exponent = exponent;

   // Run decision once the rescaled value is back.
   always_comb begin
      extend     = open_ff && (rs_rsp.value == held_ff) && (count_ff != '1);
      count_next = extend ? count_ff + {{(RUN_COUNT_BITS-1){1'b0}}, 1'b1}
                          : {{(RUN_COUNT_BITS-1){1'b0}}, 1'b1};
      held_next  = extend ? held_ff : rs_rsp.value;
      closed_run.run_value   = held_ff;
      closed_run.run_length  = 32'(count_ff);
      closed_run.bad_score   = 1'b0;
      closed_run.region_done = 1'b0;
      final_run.run_value    = held_next;
      final_run.run_length   = 32'(count_next);
      final_run.bad_score    = 1'b0;
      final_run.region_done  = 1'b1;
      bad_res.run_value      = 10'd0;
      bad_res.run_length     = 32'd0;
      bad_res.bad_score      = 1'b1;
      bad_res.region_done    = item.end_of_region && !open_ff;
   end

   // Sequencer and result register next state.
   always_comb begin
      state_in     = state_ff;
      eor_in       = eor_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      open_in      = open_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      nres_in      = nres_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (item.bad) begin
                  res0_in = bad_res;
                  res1_in = closed_run;
                  res1_in.region_done = 1'b1;
                  if (item.end_of_region && open_ff) begin
                     nres_in  = 2'd2;
                     open_in  = 1'b0;
                     count_in = '0;
                  end else begin
                     nres_in = 2'd1;
                  end
                  state_in = S_SEND;
               end else begin
                  eor_in   = item.end_of_region;
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (rs_rsp.done) begin
               held_in  = held_next;
               count_in = count_next;
               open_in  = 1'b1;
               if (!extend && open_ff) begin
                  res0_in = closed_run;
                  res1_in = final_run;
                  nres_in = eor_ff ? 2'd2 : 2'd1;
               end else begin
                  res0_in = final_run;
                  nres_in = eor_ff ? 2'd1 : 2'd0;
               end
               if (eor_ff) begin
                  open_in  = 1'b0;
                  count_in = '0;
               end
               if ((!extend && open_ff) || eor_ff) state_in = S_SEND;
               else state_in = S_IDLE;
            end
         end
         S_SEND: begin
            // Hand the pending results to the output register in order.
            if (out_free) begin
               rsp_in       = res0_ff;
               rsp_valid_in = 1'b1;
               res0_in      = res1_ff;
               nres_in      = nres_ff - 2'd1;
               if (nres_ff == 2'd1) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         nres_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         nres_ff      <= nres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eor_ff  <= eor_in;
      res0_ff <= res0_in;
      res1_ff <= res1_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the encoder's own bookkeeping.
   `PRRE_ASSERT_IMP(a_done_only_waiting, rs_rsp.done, state_ff == S_WAIT)
   `PRRE_ASSERT_NXT(a_start_enters_wait, rs_req.start, state_ff == S_WAIT)
   `PRRE_ASSERT_IMP(a_open_run_counted, open_ff, count_ff != '0)
   `PRRE_ASSERT_IMP(a_bad_result_empty, rsp_valid_ff && rsp_ff.bad_score,
      rsp_ff.run_length == 32'd0 && rsp_ff.run_value == 10'd0)

endmodule

// File: hw/rtl/power_rescale_run_length_encoder.sv
// Top level of the power rescale run-length encoder with its register port.
//
// Scores enter on the req_ channel (valid/ready); each valid score is
// rescaled to round(1000 * (score/1000)^u) and the values are run-length
// encoded into (value, length) results on the rsp_ channel (valid/ready).
// A score above 1000 yields an error result and is dropped; an item marked
// end_of_region flushes the open run. An item causes zero, one or two results.
// The exponent u (Q8.16) is written through the APB-style port at address 0;
// the user must write it only while the block is idle; the block itself does
// not enforce this. pready is always high. A score of 0 or a zero exponent
// is answered by the rescale unit straight from its idle state; otherwise
// it runs 32 squaring steps for the logarithm, two partial multiplies and 32
// coefficient steps for the power, one step per cycle. One item is rescaled
// at a time. A two-entry queue accepts up to two items ahead of the rescale
// unit, and a result register holds each result until it is taken, so a
// stalled receiver stops the back end and then, once the queue is full, the
// input. Synchronous reset empties the queue, closes any open run and
// restores the exponent to 1.0.
module power_rescale_run_length_encoder #(
   parameter int RUN_COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prre_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prre_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import prre_pkg::*;

   logic [23:0] exponent_ff, exponent_in;
   logic        item_valid, item_ready;
   item_type    item;
   rs_req_type  rs_req;
   rs_rsp_type  rs_rsp;

   // Register port.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_EXPONENT) ? {8'b0, exponent_ff} : 32'd0;

   always_comb begin
      exponent_in = exponent_ff;
      if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_EXPONENT)
         exponent_in = pwdata[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) exponent_ff <= EXPONENT_RESET;
      else exponent_ff <= exponent_in;
   end

   prre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   prre_rescale u_rescale (
      .clock  (clock),
      .reset  (reset),
      .rs_req (rs_req),
      .rs_rsp (rs_rsp)
   );

   prre_run_encoder #(
      .RUN_COUNT_BITS (RUN_COUNT_BITS)
   ) u_encoder (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .exponent   (exponent_ff),
      .rs_req     (rs_req),
      .rs_rsp     (rs_rsp),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
